// ===== sv/pidsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pidsd_pkg: shared definitions for the steering PID block
// Default widths, register indexes, reset values and the control group of
// the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pidsd_pkg;

  // Default structural widths.
  localparam int ERROR_WIDTH_DEF    = 16;
  localparam int SUM_WIDTH_DEF      = 32;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  // Register file layout.
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int GAIN_W      = 16;
  localparam int SPEED_W     = 8;
  localparam int PERIOD_W    = 16;
  localparam int COMPARE_W   = 16;
  localparam int DRIVE_OUT_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MAX   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD  = 3'd6;

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 16'd2560;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST  = 16'd102;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 16'd0;
  localparam logic [SPEED_W-1:0]  DRIVE_LIMIT_RST = 8'd80;
  localparam logic [SPEED_W-1:0]  BASE_SPEED_RST  = 8'd80;
  localparam logic [SPEED_W-1:0]  SPEED_MAX_RST   = 8'd80;
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST  = 16'd8000;

  // Division by 100 as a multiply by ceil(2^31/100) and a shift by 31.
  // Exact for dividends below 2^24 (speed times period).
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 25'd21474837;

  // Multiplier digit width and byte-shift select width.
  localparam int DIGIT_W = 8;
  localparam int SHIFT_W = 2;

  // Control group of the multiply-accumulate unit.
  typedef struct packed {
    logic               en;     // perform one accumulate step
    logic               clear;  // start a fresh sum with this product
    logic [SHIFT_W-1:0] shift;  // product weight in whole bytes
  } mac_ctrl_t;

endpackage

// ===== sv/pid_steering_differential_pwm_top.sv =====
// ----------------------------------------------------------------------------
// pid_steering_differential_pwm_top: steering PID with differential PWM
// Usage: one signed line error request enters on the input channel
// (in_valid, in_stall, line_error) once per control tick. The block updates
// its saturating error sum and previous error, forms the clamped drive value
// from the three gains, mixes it into right and left speeds and scales each
// speed to a 16-bit PWM compare value. One result request leaves on the
// output channel (out_valid, out_stall) with right_compare, left_compare,
// drive_value and integral_saturated.
// The single shared byte-by-operand multiplier does 6 steps for the three
// gain products and 4 steps per motor for the period product and the
// division by 100. in_stall is high while an item is in work. A finished
// result sits in the output register; if the receiver stalls, the sequencer
// waits with the next result until the register is free. Reset clears the
// sum, the previous error, the sequencer and out_valid, and loads the
// register defaults. The user must write registers through the port
// cfg_write/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module pid_steering_differential_pwm_top #(
  parameter int ERROR_WIDTH    = pidsd_pkg::ERROR_WIDTH_DEF,
  parameter int SUM_WIDTH      = pidsd_pkg::SUM_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = pidsd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_write,
  input  logic [pidsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pidsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ERROR_WIDTH-1:0]        line_error,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pidsd_pkg::COMPARE_W-1:0]      right_compare,
  output logic [pidsd_pkg::COMPARE_W-1:0]      left_compare,
  output logic [pidsd_pkg::DRIVE_OUT_W-1:0]    drive_value,
  output logic                                 integral_saturated
);
  import pidsd_pkg::*;

  // Derived widths.
  localparam int D_W     = ERROR_WIDTH + 1;
  localparam int SW      = ((SUM_WIDTH > ERROR_WIDTH) ? SUM_WIDTH : ERROR_WIDTH) + 1;
  localparam int OPW0    = (SUM_WIDTH > D_W) ? SUM_WIDTH : D_W;
  localparam int OPW     = (OPW0 > 32) ? OPW0 : 32;
  localparam int ACC_W   = OPW + 19;
  localparam int DRIVE_W = SPEED_W + GAIN_FRAC_BITS;
  localparam int QW      = DRIVE_W + 2;
  localparam int CMP_W   = ACC_W - RECIP_SHIFT;
  localparam int X_W     = SPEED_W + PERIOD_W;

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PID   = 3'd1;
  localparam logic [2:0] ST_CLAMP = 3'd2;
  localparam logic [2:0] ST_SPEED = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [2:0] PID_LAST = 3'd5;
  localparam logic [2:0] DIV_LAST = 3'd2;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  // Configuration registers.
  logic [GAIN_W-1:0]   prop_gain;
  logic [GAIN_W-1:0]   integ_gain;
  logic [GAIN_W-1:0]   deriv_gain;
  logic [SPEED_W-1:0]  drive_limit;
  logic [SPEED_W-1:0]  base_speed;
  logic [SPEED_W-1:0]  speed_max;
  logic [PERIOD_W-1:0] pwm_period;

  // Controller state and work registers.
  logic [2:0]                   state;
  logic [2:0]                   step;
  logic                         side;
  logic signed [SUM_WIDTH-1:0]  error_sum;
  logic signed [ERROR_WIDTH-1:0] last_error;
  logic signed [ERROR_WIDTH-1:0] err;
  logic signed [D_W-1:0]        diff;
  logic                         sat;
  logic [DRIVE_W-1:0]           drive;
  logic [X_W-1:0]               xval;
  logic [COMPARE_W-1:0]         right_cmp;
  logic [COMPARE_W-1:0]         left_cmp;

  // Datapath signals.
  logic                         in_accept;
  logic                         out_free;
  logic signed [SW-1:0]         sum_wide;
  logic [SW-SUM_WIDTH:0]        sum_top;
  logic                         sum_ovf;
  logic signed [SUM_WIDTH-1:0]  sum_sat;
  logic signed [D_W-1:0]        diff_next;
  mac_ctrl_t                    mac_ctrl;
  logic [DIGIT_W-1:0]           mac_digit;
  logic signed [OPW-1:0]        mac_operand;
  logic signed [ACC_W-1:0]      acc;
  logic [GAIN_W-1:0]            gain_sel;
  logic [DRIVE_W-1:0]           lim;
  logic signed [ACC_W-1:0]      lim_acc;
  logic [DRIVE_W-1:0]           drive_next;
  logic signed [QW-1:0]         base_q;
  logic signed [QW-1:0]         drive_q;
  logic signed [QW-1:0]         speed_q;
  logic signed [QW-1:0]         speed_whole;
  logic signed [QW-1:0]         max_q;
  logic [SPEED_W-1:0]           speed;
  logic [CMP_W-1:0]             cmp_wide;
  logic [COMPARE_W-1:0]         cmp;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= PROP_GAIN_RST;
      integ_gain  <= INTEG_GAIN_RST;
      deriv_gain  <= DERIV_GAIN_RST;
      drive_limit <= DRIVE_LIMIT_RST;
      base_speed  <= BASE_SPEED_RST;
      speed_max   <= SPEED_MAX_RST;
      pwm_period  <= PWM_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROP_GAIN:   prop_gain   <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain  <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain  <= cfg_data[GAIN_W-1:0];
        REG_DRIVE_LIMIT: drive_limit <= cfg_data[SPEED_W-1:0];
        REG_BASE_SPEED:  base_speed  <= cfg_data[SPEED_W-1:0];
        REG_SPEED_MAX:   speed_max   <= cfg_data[SPEED_W-1:0];
        REG_PWM_PERIOD:  pwm_period  <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating error sum and first difference of the new sample.
  always_comb begin
    sum_wide  = SW'(error_sum) + SW'(line_error);
    sum_top   = sum_wide[SW-1:SUM_WIDTH-1];
    sum_ovf   = !((&sum_top) || (~|sum_top));
    sum_sat   = sum_ovf ? (sum_wide[SW-1] ? SUM_MIN : SUM_MAX)
                        : sum_wide[SUM_WIDTH-1:0];
    diff_next = D_W'(line_error) - D_W'(last_error);
  end

  // Clamp of the accumulated controller output to 0..limit.
  always_comb begin
    lim     = DRIVE_W'(drive_limit) << GAIN_FRAC_BITS;
    lim_acc = ACC_W'(lim);
    if (acc < 0) begin
      drive_next = '0;
    end else if (acc > lim_acc) begin
      drive_next = lim;
    end else begin
      drive_next = acc[DRIVE_W-1:0];
    end
  end

  // Steering mix and speed clamp; side 0 is the right motor.
  always_comb begin
    base_q      = QW'(DRIVE_W'(base_speed) << GAIN_FRAC_BITS);
    drive_q     = QW'(drive);
    speed_q     = side ? (base_q - drive_q) : (base_q + drive_q);
    speed_whole = speed_q >>> GAIN_FRAC_BITS;
    max_q       = QW'(speed_max);
    if (speed_q < 0) begin
      speed = '0;
    end else if (speed_whole > max_q) begin
      speed = speed_max;
    end else begin
      speed = speed_whole[SPEED_W-1:0];
    end
  end

  // Quotient by 100 from the accumulator, saturated to the compare width.
  always_comb begin
    cmp_wide = acc[ACC_W-1:RECIP_SHIFT];
    cmp      = (|cmp_wide[CMP_W-1:COMPARE_W]) ? {COMPARE_W{1'b1}}
                                               : cmp_wide[COMPARE_W-1:0];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (step[2:1])
      2'd0:    gain_sel = prop_gain;
      2'd1:    gain_sel = integ_gain;
      2'd2:    gain_sel = deriv_gain;
      default: gain_sel = '0;
    endcase
    mac_ctrl    = '0;
    mac_digit   = '0;
    mac_operand = '0;
    case (state)
      ST_PID: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = (step == 3'd0);
        mac_ctrl.shift = SHIFT_W'(step[0]);
        mac_digit      = step[0] ? gain_sel[15:8] : gain_sel[7:0];
        case (step[2:1])
          2'd0:    mac_operand = OPW'(err);
          2'd1:    mac_operand = OPW'(error_sum);
          default: mac_operand = OPW'(diff);
        endcase
      end
      ST_SPEED: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = 1'b1;
        mac_digit      = speed;
        mac_operand    = OPW'(pwm_period);
      end
      ST_DIV: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = (step == 3'd0);
        mac_ctrl.shift = step[SHIFT_W-1:0];
        mac_operand    = OPW'(RECIP_MULT);
        case (step[1:0])
          2'd0:    mac_digit = acc[7:0];
          2'd1:    mac_digit = xval[15:8];
          default: mac_digit = xval[23:16];
        endcase
      end
      default: ;
    endcase
  end

  pidsd_mac #(
    .B_W   (OPW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .digit   (mac_digit),
    .operand (mac_operand),
    .acc     (acc)
  );

  // Sequencer and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      side       <= 1'b0;
      error_sum  <= '0;
      last_error <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            error_sum  <= sum_sat;
            last_error <= line_error;
            state      <= ST_PID;
            step       <= '0;
          end
        end
        ST_PID: begin
          if (step == PID_LAST) begin
            state <= ST_CLAMP;
            step  <= '0;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_CLAMP: begin
          side  <= 1'b0;
          state <= ST_SPEED;
        end
        ST_SPEED: begin
          state <= ST_DIV;
          step  <= '0;
        end
        ST_DIV: begin
          if (step == DIV_LAST) begin
            state <= ST_STORE;
            step  <= '0;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_STORE: begin
          if (side) begin
            state <= ST_DONE;
          end else begin
            side  <= 1'b1;
            state <= ST_SPEED;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Work registers and the output register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      err  <= line_error;
      diff <= diff_next;
      sat  <= sum_ovf;
    end
    if (state == ST_CLAMP) begin
      drive <= drive_next;
    end
    if (state == ST_DIV && step == 3'd0) begin
      xval <= acc[X_W-1:0];
    end
    if (state == ST_STORE && !side) begin
      right_cmp <= cmp;
    end
    if (state == ST_STORE && side) begin
      left_cmp <= cmp;
    end
    if (state == ST_DONE && out_free) begin
      right_compare      <= right_cmp;
      left_compare       <= left_cmp;
      drive_value        <= DRIVE_OUT_W'(drive);
      integral_saturated <= sat;
    end
  end

  // The clamped drive never exceeds the configured limit.
  a_drive_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (drive <= lim))
    else $error("drive above limit");

  // A new result appears only from the final sequencer state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == ST_DONE))
    else $error("result without completed item");

  // An accepted request starts the gain products at the first step.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_PID && step == 3'd0))
    else $error("sequencer did not start");

endmodule

// ===== sv/pidsd_mac.sv =====
// ----------------------------------------------------------------------------
// pidsd_mac: shared multiply-accumulate unit
// Multiplies an unsigned byte digit by a signed operand, weights the product
// by a whole number of bytes and adds it into a signed accumulator.
// ----------------------------------------------------------------------------
module pidsd_mac #(
  parameter int B_W   = 32,
  parameter int ACC_W = 51
) (
  input  logic                   clk,
  input  pidsd_pkg::mac_ctrl_t   ctrl,
  input  logic [pidsd_pkg::DIGIT_W-1:0] digit,
  input  logic signed [B_W-1:0]  operand,
  output logic signed [ACC_W-1:0] acc
);
  import pidsd_pkg::*;

  logic signed [DIGIT_W+B_W:0] prod;
  logic signed [ACC_W-1:0]     prod_ext;
  logic signed [ACC_W-1:0]     prod_shifted;
  logic signed [ACC_W-1:0]     acc_base;
  logic signed [ACC_W-1:0]     acc_next;

  // One digit product, weighted and added into the running sum.
  always_comb begin
    prod         = $signed({1'b0, digit}) * operand;
    prod_ext     = ACC_W'(prod);
    prod_shifted = prod_ext <<< {ctrl.shift, 3'b000};
    acc_base     = ctrl.clear ? '0 : acc;
    acc_next     = acc_base + prod_shifted;
  end

  // Accumulator is payload only; the sequencer always clears before use.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= acc_next;
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering PID regression bench
// Drives line error requests into the steering PID block, predicts the drive
// value and both PWM compare values with a behavioral copy of the loop, and
// checks each result request in order. Directed cases cover the drive,
// speed and compare clamps, the register write masking and the derivative
// path. Random phases run with fresh settings, back-pressure and idle gaps
// on both channels. The run closes with a long unbroken stream that winds
// the error sum far negative and then steps back out of it.
// ----------------------------------------------------------------------------
module testbench;
  import pidsd_pkg::*;

  localparam int ERR_W = ERROR_WIDTH_DEF;
  localparam int SUM_W = SUM_WIDTH_DEF;
  localparam int FRAC  = GAIN_FRAC_BITS_DEF;

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam longint SUM_MAX     = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_MIN     = -SUM_MAX - 1;
  localparam longint ITERM_BOUND = longint'(1) << 61;
  localparam longint PCT_FULL    = 100;
  localparam longint COMPARE_MAX = 65535;

  // The only index that maps to no register.
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 3'd7;

  localparam int RANDOM_PHASES    = 10;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int LONG_HOLD        = 300;
  localparam int DRAIN_CYCLES     = 40;
  localparam int WINDUP_SAMPLES   = 48;
  localparam int RELEASE_SAMPLES  = 16;

  typedef struct packed {
    logic [COMPARE_W-1:0]   right_cmp;
    logic [COMPARE_W-1:0]   left_cmp;
    logic [DRIVE_OUT_W-1:0] drive;
    logic                   sat;
  } pwm_result_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_write;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [ERR_W-1:0] line_error;
  logic                    out_valid;
  logic                    out_stall;
  logic [COMPARE_W-1:0]    right_compare;
  logic [COMPARE_W-1:0]    left_compare;
  logic [DRIVE_OUT_W-1:0]  drive_value;
  logic                    integral_saturated;

  // Loop state and register copies used for prediction.
  longint error_sum_model;
  longint prev_error_model;
  int     prop_gain_m;
  int     integ_gain_m;
  int     deriv_gain_m;
  int     drive_limit_m;
  int     base_speed_m;
  int     speed_max_m;
  int     pwm_period_m;

  pwm_result_t expected_pwm[$];
  int unsigned fail_count = 0;
  logic        source_idling = 1'b0;
  logic        sink_idling = 1'b0;
  int          hold_cycles = 0;

  pid_steering_differential_pwm_top u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .line_error         (line_error),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .right_compare      (right_compare),
    .left_compare       (left_compare),
    .drive_value        (drive_value),
    .integral_saturated (integral_saturated)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor a signed Q10.8 speed to whole units and clamp it to 0..speed_max.
  function automatic int speed_from_q(input longint q);
    if (q < 0) return 0;
    if ((q >>> FRAC) > speed_max_m) return speed_max_m;
    return int'(q >>> FRAC);
  endfunction

  // Scale a speed to timer counts, saturating at the compare width.
  function automatic logic [COMPARE_W-1:0] compare_from_speed(input int speed);
    longint counts;
    counts = longint'(speed) * longint'(pwm_period_m) / PCT_FULL;
    if (counts > COMPARE_MAX) return COMPARE_W'(COMPARE_MAX);
    return COMPARE_W'(counts);
  endfunction

  // Advance the loop state by one error sample and return the wheel outputs.
  function automatic pwm_result_t next_wheel_pwm(input logic signed [ERR_W-1:0] err);
    longint      e;
    longint      s;
    longint      pterm;
    longint      iterm;
    longint      dterm;
    longint      lim;
    longint      base_q;
    longint      drive;
    pwm_result_t r;
    e = longint'(err);
    s = error_sum_model + e;
    r.sat = 1'b0;
    if (s > SUM_MAX) begin
      s = SUM_MAX;
      r.sat = 1'b1;
    end
    if (s < SUM_MIN) begin
      s = SUM_MIN;
      r.sat = 1'b1;
    end
    pterm = longint'(prop_gain_m) * e;
    iterm = longint'(integ_gain_m) * s;
    if (iterm > ITERM_BOUND) iterm = ITERM_BOUND;
    if (iterm < -ITERM_BOUND) iterm = -ITERM_BOUND;
    dterm = longint'(deriv_gain_m) * (e - prev_error_model);

    // Clamp the drive to 0..limit whole units.
    lim = longint'(drive_limit_m) << FRAC;
    drive = pterm + iterm + dterm;
    if (drive > lim) drive = lim;
    if (drive < 0) drive = 0;

    // Differential mix: the right wheel speeds up, the left slows down.
    base_q = longint'(base_speed_m) << FRAC;
    r.right_cmp = compare_from_speed(speed_from_q(base_q + drive));
    r.left_cmp = compare_from_speed(speed_from_q(base_q - drive));
    r.drive = DRIVE_OUT_W'(drive);

    error_sum_model = s;
    prev_error_model = e;
    return r;
  endfunction

  // Random error: mostly small, some full range and extremes, and some that
  // pull the error sum back toward zero so the drive stays inside its clamps.
  function automatic logic signed [ERR_W-1:0] pick_error();
    longint pull;
    case ($urandom_range(0, 9))
      0: return ERR_W'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? ERR_MAX : ERR_MIN;
      2, 3: begin
        pull = -error_sum_model + longint'($urandom_range(0, 64)) - 32;
        if (pull > ERR_MAX) pull = ERR_MAX;
        if (pull < ERR_MIN) pull = ERR_MIN;
        return ERR_W'(pull);
      end
      default: return ERR_W'(int'($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  // Sixteen-bit register value, biased toward small numbers and the extremes.
  function automatic logic [CFG_DATA_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, 1024));
    endcase
  endfunction

  // Eight-bit register value with random junk in the unused upper byte.
  function automatic logic [CFG_DATA_W-1:0] rand_byte();
    logic [SPEED_W-1:0] val;
    case ($urandom_range(0, 4))
      0: val = '0;
      1: val = '1;
      default: val = SPEED_W'($urandom);
    endcase
    return {8'($urandom), val};
  endfunction

  // One register write; only the low bits of the register's width are kept.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_PROP_GAIN:   prop_gain_m = int'(data);
      REG_INTEG_GAIN:  integ_gain_m = int'(data);
      REG_DERIV_GAIN:  deriv_gain_m = int'(data);
      REG_DRIVE_LIMIT: drive_limit_m = int'(data[SPEED_W-1:0]);
      REG_BASE_SPEED:  base_speed_m = int'(data[SPEED_W-1:0]);
      REG_SPEED_MAX:   speed_max_m = int'(data[SPEED_W-1:0]);
      REG_PWM_PERIOD:  pwm_period_m = int'(data);
      default: ;
    endcase
  endtask

  // Drop valid and hold until every expected result has been received.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pwm.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] kp, ki, kd, limit, base,
                           smax, period);
    wait_idle();
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_DRIVE_LIMIT, limit);
    write_reg(REG_BASE_SPEED, base);
    write_reg(REG_SPEED_MAX, smax);
    write_reg(REG_PWM_PERIOD, period);
  endtask

  // Offer one error request, with an optional idle burst first, and record
  // the expected result once the block takes it.
  task automatic send_error(input logic signed [ERR_W-1:0] err);
    int gap;
    if (source_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid = 1'b0;
      line_error = ERR_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    line_error = err;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pwm.push_back(next_wheel_pwm(err));
  endtask

  // Reset gains: zero, small errors and the field extremes.
  task automatic test_reset_defaults();
    send_error('0);
    send_error(ERR_W'(100));
    send_error(-ERR_W'(100));
    send_error(ERR_MAX);
    send_error(ERR_MIN);
  endtask

  // Gain 1.5 with a limit of 40: a fractional drive, drive in range, above
  // the limit, and a negative drive.
  task automatic test_drive_clamps();
    configure(16'd384, 16'd0, 16'd0, 16'd40, 16'd100, 16'd200, 16'd100);
    send_error(ERR_W'(7));
    send_error(ERR_W'(10));
    send_error(ERR_W'(27));
    send_error(-ERR_W'(5));
  endtask

  // Right speed above speed_max, and a left speed pushed below zero.
  task automatic test_speed_clamps();
    configure(16'd256, 16'd0, 16'd0, 16'd255, 16'd250, 16'd120, 16'd1000);
    send_error(ERR_W'(30));
    send_error(ERR_W'(255));
  endtask

  // Full speed on both wheels with periods around the compare saturation.
  task automatic test_compare_saturation();
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd255, 16'd255, 16'hFFFF);
    send_error(ERR_W'(3));
    wait_idle();
    write_reg(REG_PWM_PERIOD, 16'd0);
    send_error(ERR_W'(3));
    wait_idle();
    write_reg(REG_PWM_PERIOD, 16'd25700);
    send_error(ERR_W'(3));
    wait_idle();
    write_reg(REG_PWM_PERIOD, 16'd25701);
    send_error(ERR_W'(3));
  endtask

  // Derivative term alone, including the widest possible error step.
  task automatic test_derivative();
    configure(16'd0, 16'd0, 16'd256, 16'd255, 16'd128, 16'd255, 16'd100);
    send_error(ERR_W'(20));
    send_error(ERR_W'(5));
    send_error(ERR_W'(25));
    send_error(ERR_MIN);
    send_error(ERR_MAX);
  endtask

  // Upper bytes of the 8-bit registers are dropped; the spare index does
  // nothing.
  task automatic test_register_masking();
    configure(16'd256, 16'd0, 16'd0, 16'hAB05, 16'h7F64, 16'h01C8, 16'd100);
    write_reg(CFG_INDEX_SPARE, 16'hFFFF);
    send_error(ERR_W'(50));
    send_error(-ERR_W'(50));
  endtask

  // Random settings per phase, the first two at the register extremes.
  task automatic test_random_phases();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        configure('1, '1, '1, 16'd255, 16'd255, 16'd255, '1);
      else if (phase == 1)
        configure('0, '0, '0, '0, '0, '0, '0);
      else begin
        configure(rand_word(), rand_word(), rand_word(), rand_byte(), rand_byte(),
                  rand_byte(), rand_word());
        write_reg(CFG_INDEX_SPARE, CFG_DATA_W'($urandom));
      end
      source_idling = (phase % 3) != 2;
      sink_idling = (phase % 4) != 3;
      repeat (RANDOM_PER_PHASE) send_error(pick_error());
    end
  endtask

  // The receiver holds off long enough for the block to stall its input,
  // then the sender pauses until everything has drained.
  task automatic test_backpressure();
    wait_idle();
    source_idling = 1'b0;
    sink_idling = 1'b0;
    hold_cycles = LONG_HOLD;
    repeat (8) send_error(pick_error());
    wait_idle();
    source_idling = 1'b1;
    sink_idling = 1'b1;
    repeat (20) send_error(pick_error());
  endtask

  // Wind the error sum far negative with the most negative sample, then
  // step back out with the most positive one. No idling from here on.
  task automatic test_integral_windup();
    configure(16'd256, 16'd1, 16'hFFFF, 16'd255, 16'd128, 16'd255, 16'd200);
    source_idling = 1'b0;
    sink_idling = 1'b0;
    repeat (WINDUP_SAMPLES) send_error(ERR_MIN);
    repeat (RELEASE_SAMPLES) send_error(ERR_MAX);
  endtask

  // Receiver: random stall bursts, plus the long hold when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_stall = 1'b0;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    pwm_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pwm.size() == 0) begin
        $error("result with no request outstanding: right %0d left %0d drive %0d",
               right_compare, left_compare, drive_value);
        fail_count++;
      end else begin
        want = expected_pwm.pop_front();
        if (right_compare !== want.right_cmp) begin
          $error("right_compare: expected %0d, actual %0d", want.right_cmp,
                 right_compare);
          fail_count++;
        end
        if (left_compare !== want.left_cmp) begin
          $error("left_compare: expected %0d, actual %0d", want.left_cmp, left_compare);
          fail_count++;
        end
        if (drive_value !== want.drive) begin
          $error("drive_value: expected %0d, actual %0d", want.drive, drive_value);
          fail_count++;
        end
        if (integral_saturated !== want.sat) begin
          $error("integral_saturated: expected %0d, actual %0d", want.sat,
                 integral_saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Test sequence.
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_PROP_GAIN;
    cfg_data = '0;
    in_valid = 1'b0;
    line_error = '0;
    error_sum_model = 0;
    prev_error_model = 0;
    prop_gain_m = int'(PROP_GAIN_RST);
    integ_gain_m = int'(INTEG_GAIN_RST);
    deriv_gain_m = int'(DERIV_GAIN_RST);
    drive_limit_m = int'(DRIVE_LIMIT_RST);
    base_speed_m = int'(BASE_SPEED_RST);
    speed_max_m = int'(SPEED_MAX_RST);
    pwm_period_m = int'(PWM_PERIOD_RST);
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_drive_clamps();
    test_speed_clamps();
    test_compare_saturation();
    test_derivative();
    test_register_masking();
    test_random_phases();
    test_backpressure();
    test_integral_windup();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
